// ===== hdl/nearest_palette_color_match_unit_defines.svh =====
// Assertion macros for the palette match unit
`ifndef NEAREST_PALETTE_COLOR_MATCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define NPCM_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define NPCM_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/npcm_pkg.sv =====
`default_nettype none

package npcm_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CHAN_W = 8;
  localparam int SQ_W = 16;
  localparam int DIST_W = 18;
  localparam int ENTRY_W = 3 * CHAN_W;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] c5);
    return {c5, 3'b100};
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/npcm_ram.sv =====
`default_nettype none

module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_color_match_unit.sv =====
// Nearest palette colour match.
// Input stream (s_axis_*): tuser[0] selects the command, 0 writes a palette
// entry, 1 looks up a 15-bit colour. Output stream (m_axis_*) carries one
// word per lookup: nearest entry index and squared distance. Writes give
// no output word.
// A write leaves the input ready; writes to the last entry or beyond the
// palette are dropped, the last entry always reads as black.
// A lookup streams all PALETTE_ENTRIES entries out of the palette RAM, one
// per cycle through its single read port, then through the square and
// sum/compare pipeline stages before the result word is loaded.
// s_axis_tready is low during a search. A finished result sits in the output
// register, so new words are taken while the receiver stalls; a following
// search waits at its end until that register is free.
// Reset clears the control state; palette contents are not cleared and
// every entry except the last must be written before the first lookup.
`default_nettype none

module nearest_palette_color_match_unit
  import npcm_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
  // [46:32] color15, [47] zero
  input  wire logic [47:0] s_axis_tdata,
  // [0] cmd
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] nearest_index, [25:8] best_distance_sq, [31:26] zero
  output logic      [31:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [7:0] LAST_IDX8 = 8'(PALETTE_ENTRIES - 1);

  state_t state, state_next;

  logic              accept;
  logic              is_lookup;
  logic              wr_en;
  logic              rd_en;
  logic              load_out;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;

  logic [IDX_W-1:0]  cnt;
  logic              rd_vld;
  logic              rd_last;
  logic [IDX_W-1:0]  rd_idx;
  logic              sq_vld;
  logic [IDX_W-1:0]  sq_idx;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] dist_sum;
  logic              first;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0]  best_idx;
  logic [CHAN_W-1:0] col_r, col_g, col_b;
  logic [7:0]        out_idx;
  logic [DIST_W-1:0] out_dist;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_lookup = (s_axis_tuser[0] == CMD_LOOKUP);
  assign wr_en     = accept && !is_lookup && (s_axis_tdata[7:0] < LAST_IDX8);

  npcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_axis_tdata[IDX_W-1:0]),
    .wr_data ({s_axis_tdata[31:24], s_axis_tdata[23:16], s_axis_tdata[15:8]}),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && is_lookup) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !sq_vld && (!m_axis_tvalid || m_axis_tready)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      rd_vld        <= 1'b0;
      sq_vld        <= 1'b0;
      first         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      sq_vld <= rd_vld;
      if (accept && is_lookup) begin
        cnt   <= '0;
        first <= 1'b1;
      end else begin
        if (rd_en) begin
          cnt <= cnt + 1'b1;
        end
        if (sq_vld) begin
          first <= 1'b0;
        end
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // last entry is fixed black, the RAM word there is never written
  assign entry    = rd_last ? '0 : rd_data;
  assign dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (accept && is_lookup) begin
      col_r <= expand5(s_axis_tdata[36:32]);
      col_g <= expand5(s_axis_tdata[41:37]);
      col_b <= expand5(s_axis_tdata[46:42]);
    end
    rd_idx  <= cnt;
    rd_last <= (cnt == LAST_IDX);
    sq_r    <= sq_diff(col_r, entry[7:0]);
    sq_g    <= sq_diff(col_g, entry[15:8]);
    sq_b    <= sq_diff(col_b, entry[23:16]);
    sq_idx  <= rd_idx;
    // strict compare keeps the lowest index on a tie
    if (sq_vld && (first || (dist_sum < best))) begin
      best     <= dist_sum;
      best_idx <= sq_idx;
    end
    if (load_out) begin
      out_idx  <= 8'(best_idx);
      out_dist <= best;
    end
  end

  assign m_axis_tdata = {6'b0, out_dist, out_idx};

endmodule

`default_nettype wire

// ===== hdl/npcm_checker.sv =====
`default_nettype none
`include "nearest_palette_color_match_unit_defines.svh"

module npcm_checker
  import npcm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  `NPCM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output word dropped or changed while stalled")

  `NPCM_ASSERT_NEXT(a_lookup_busy, clk, rst,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_LOOKUP),
    !s_axis_tready, "input taken during a search")

  `NPCM_ASSERT_NEXT(a_write_quick, clk, rst,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_WRITE),
    s_axis_tready, "palette write blocked the input")

  `NPCM_ASSERT_SAME(a_result_from_search, clk, rst, $rose(m_axis_tvalid),
    $past(!s_axis_tready) && (m_axis_tdata[25:8] <= DIST_MAX),
    "result word without a search or distance out of range")

endmodule

bind nearest_palette_color_match_unit npcm_checker u_npcm_checker (.*);

`default_nettype wire
